// File: hw/rtl/spmf_pkg.sv
// spmf_pkg: shared sizes, codes and types for the strict priority multi fifo
// no dependencies; imported by spmf_ctrl, spmf_dp, strict_priority_multi_fifo and the tb files
package spmf_pkg;

   localparam int LEVELS  = 4;
   localparam int DEPTH   = 4;
   localparam int LEVEL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int ADDR_W  = $clog2(LEVELS * DEPTH);

   localparam int PRIO_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;

   typedef enum logic [STATUS_W-1:0] {
      STAT_INSERTED = 3'd0,
      STAT_FULL     = 3'd1,
      STAT_BADPRIO  = 3'd2,
      STAT_REMOVED  = 3'd3,
      STAT_EMPTY    = 3'd4
   } spmf_status_type;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_REMOVE = 1'b1
   } spmf_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } spmf_state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic respond;
   } spmf_cmd_type;

endpackage

// File: hw/rtl/spmf_ctrl.sv
// spmf_ctrl: sequencer for one word at a time (accept, execute, respond)
// depends on spmf_pkg; drives the command struct of spmf_dp
module spmf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output spmf_pkg::spmf_cmd_type cmd
);
   import spmf_pkg::*;

   spmf_state_type state_ff;
   spmf_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy        = 1'b1;
      cmd.load    = 1'b0;
      cmd.exec    = 1'b0;
      cmd.respond = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         ST_RESP: begin
            cmd.respond = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   a_accept_leads_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.exec)
      else $error("accepted word not executed next cycle");

   a_exec_leads_resp: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> cmd.respond)
      else $error("execute not followed by response");

   a_resp_frees: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> !busy)
      else $error("still busy after response");

endmodule

// File: hw/rtl/spmf_dp.sv
// spmf_dp: level rings, counts, entry memory and result registers
// depends on spmf_pkg; sequenced by spmf_ctrl
module spmf_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  spmf_pkg::spmf_cmd_type        cmd,
   input  logic                          req_kind,
   input  logic [spmf_pkg::PRIO_W-1:0]   req_priority_req,
   input  logic signed [spmf_pkg::VALUE_W-1:0] req_value,
   output logic [spmf_pkg::STATUS_W-1:0] rsp_status,
   output logic signed [spmf_pkg::VALUE_W-1:0] rsp_out_value,
   output logic [spmf_pkg::PRIO_W-1:0]   rsp_served_level
);
   import spmf_pkg::*;

   logic                 kind_ff;
   logic [PRIO_W-1:0]    prio_ff;
   logic [VALUE_W-1:0]   value_ff;

   logic [PTR_W-1:0]     head_ff  [LEVELS];
   logic [PTR_W-1:0]     tail_ff  [LEVELS];
   logic [COUNT_W-1:0]   count_ff [LEVELS];
   logic [PTR_W-1:0]     head_in  [LEVELS];
   logic [PTR_W-1:0]     tail_in  [LEVELS];
   logic [COUNT_W-1:0]   count_in [LEVELS];

   logic [VALUE_W-1:0]   mem [LEVELS * DEPTH];
   logic [VALUE_W-1:0]   rd_data_ff;

   spmf_status_type      status_ff;
   spmf_status_type      status_in;
   logic [PRIO_W-1:0]    level_ff;
   logic [PRIO_W-1:0]    level_in;

   logic                 prio_ok;
   logic [LEVEL_W-1:0]   ins_row;
   logic                 ins_full;
   logic                 any_nonempty;
   logic [LEVEL_W-1:0]   rem_row;
   logic                 wr_en;
   logic                 rd_en;
   logic [ADDR_W-1:0]    addr;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] pos);
      ring_next = (32'(pos) >= DEPTH - 1) ? '0 : PTR_W'(32'(pos) + 1);
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         prio_ff  <= req_priority_req;
         value_ff <= req_value;
      end
   end

   assign prio_ok  = (prio_ff != '0) && (32'(prio_ff) <= LEVELS);
   assign ins_row  = LEVEL_W'(32'(prio_ff) - 1);
   assign ins_full = prio_ok && (32'(count_ff[ins_row]) >= DEPTH);

   always_comb begin
      any_nonempty = 1'b0;
      rem_row      = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (count_ff[i] != '0) begin
            any_nonempty = 1'b1;
            rem_row      = LEVEL_W'(i);
         end
      end
   end

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      status_in = status_ff;
      level_in  = level_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      addr      = '0;
      if (cmd.exec) begin
         if (kind_ff == KIND_INSERT) begin
            if (!prio_ok) begin
               status_in = STAT_BADPRIO;
               level_in  = '0;
            end else if (ins_full) begin
               status_in = STAT_FULL;
               level_in  = '0;
            end else begin
               status_in         = STAT_INSERTED;
               level_in          = prio_ff;
               wr_en             = 1'b1;
               addr              = ADDR_W'(32'(ins_row) * DEPTH + 32'(tail_ff[ins_row]));
               tail_in[ins_row]  = ring_next(tail_ff[ins_row]);
               count_in[ins_row] = count_ff[ins_row] + COUNT_W'(1);
            end
         end else begin
            if (any_nonempty) begin
               status_in         = STAT_REMOVED;
               level_in          = PRIO_W'(32'(rem_row) + 1);
               rd_en             = 1'b1;
               addr              = ADDR_W'(32'(rem_row) * DEPTH + 32'(head_ff[rem_row]));
               head_in[rem_row]  = ring_next(head_ff[rem_row]);
               count_in[rem_row] = count_ff[rem_row] - COUNT_W'(1);
            end else begin
               status_in = STAT_EMPTY;
               level_in  = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      level_ff  <= level_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= value_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_out_value    = (status_ff == STAT_REMOVED) ? rd_data_ff : '0;
   assign rsp_served_level = level_ff;

   for (genvar g = 0; g < LEVELS; g++) begin : g_count_chk
      a_count_bound: assert property (@(posedge clock) disable iff (reset)
         32'(count_ff[g]) <= DEPTH)
         else $error("level count above depth");
   end

   a_empty_report: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && kind_ff == KIND_REMOVE && !any_nonempty) |=> status_ff == STAT_EMPTY)
      else $error("remove on empty levels not reported as empty");

   a_remove_level: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && kind_ff == KIND_REMOVE && any_nonempty)
         |=> (status_ff == STAT_REMOVED) && (level_ff != '0 || LEVELS > 7))
      else $error("remove from non-empty levels lost");

endmodule

// File: hw/rtl/strict_priority_multi_fifo.sv
// strict_priority_multi_fifo: top level, one ring fifo per priority level
// depends on spmf_pkg, spmf_ctrl and spmf_dp
// timing: the edge that accepts a word moves the sequencer to execute, then to respond,
// where the result strobe is high; no new word is taken until the accept/execute/respond
// sequence around the registered read of the entry memory ends; the receiver cannot stall
// reset clears counts and ring pointers at once; the entry memory is not cleared
module strict_priority_multi_fifo (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_kind,
   input  logic [spmf_pkg::PRIO_W-1:0]         req_priority_req,
   input  logic signed [spmf_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_strobe,
   output logic [spmf_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [spmf_pkg::VALUE_W-1:0] rsp_out_value,
   output logic [spmf_pkg::PRIO_W-1:0]         rsp_served_level
);
   import spmf_pkg::*;

   spmf_cmd_type cmd;

   spmf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   spmf_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_kind         (req_kind),
      .req_priority_req (req_priority_req),
      .req_value        (req_value),
      .rsp_status       (rsp_status),
      .rsp_out_value    (rsp_out_value),
      .rsp_served_level (rsp_served_level)
   );

   assign rsp_strobe = cmd.respond;

endmodule

// File: tb/spmf_checker.sv
// spmf_checker: watches the command and result channels of strict_priority_multi_fifo,
// predicts every result word from its own copy of the level rings and compares them
// depends on spmf_pkg; instantiated beside the block by tb_strict_priority_multi_fifo
module spmf_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic                                req_kind,
   input  logic [spmf_pkg::PRIO_W-1:0]         req_priority_req,
   input  logic signed [spmf_pkg::VALUE_W-1:0] req_value,
   input  logic                                rsp_strobe,
   input  logic [spmf_pkg::STATUS_W-1:0]       rsp_status,
   input  logic signed [spmf_pkg::VALUE_W-1:0] rsp_out_value,
   input  logic [spmf_pkg::PRIO_W-1:0]         rsp_served_level,
   output int                                  error_count,
   output int                                  pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import spmf_pkg::*;

   typedef struct packed {
      spmf_status_type             status;
      logic signed [VALUE_W-1:0]   value;
      logic [PRIO_W-1:0]           level;
   } outcome_type;

   logic signed [VALUE_W-1:0] ring_data [LEVELS][DEPTH];
   int                        head_pos [LEVELS];
   int                        tail_pos [LEVELS];
   int                        fill [LEVELS];
   outcome_type               awaited_outcomes [$];
   outcome_type               want;

   function automatic outcome_type serve_word(input logic kind,
                                              input logic [PRIO_W-1:0] prio,
                                              input logic signed [VALUE_W-1:0] value);
      outcome_type res;
      int          row;
      bit          found;
      res.status = STAT_EMPTY;
      res.value  = '0;
      res.level  = '0;
      found      = 1'b0;
      if (kind == KIND_INSERT) begin
         if (prio < 1 || prio > LEVELS) begin
            res.status = STAT_BADPRIO;
         end else if (fill[prio-1] >= DEPTH) begin
            res.status = STAT_FULL;
         end else begin
            row = prio - 1;
            ring_data[row][tail_pos[row]] = value;
            tail_pos[row] = (tail_pos[row] + 1 >= DEPTH) ? 0 : tail_pos[row] + 1;
            fill[row]++;
            res.status = STAT_INSERTED;
            res.level  = prio;
         end
      end else begin
         for (row = 0; row < LEVELS; row++) begin
            if (!found && fill[row] != 0) begin
               found      = 1'b1;
               res.status = STAT_REMOVED;
               res.value  = ring_data[row][head_pos[row]];
               res.level  = PRIO_W'(row + 1);
               head_pos[row] = (head_pos[row] + 1 >= DEPTH) ? 0 : head_pos[row] + 1;
               fill[row]--;
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            head_pos[i] = 0;
            tail_pos[i] = 0;
            fill[i]     = 0;
         end
         awaited_outcomes.delete();
      end else begin
         if (rsp_strobe) begin
            if (awaited_outcomes.size() == 0) begin
               $error("result word with none expected: status %0d, out_value %0d, level %0d",
                      rsp_status, rsp_out_value, rsp_served_level);
               error_count++;
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  error_count++;
               end
               if (rsp_out_value !== want.value) begin
                  $error("out_value: expected %0d, got %0d", want.value, rsp_out_value);
                  error_count++;
               end
               if (rsp_served_level !== want.level) begin
                  $error("served_level: expected %0d, got %0d", want.level, rsp_served_level);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            awaited_outcomes.push_back(serve_word(req_kind, req_priority_req, req_value));
         end
      end
      pending_count <= awaited_outcomes.size();
   end

endmodule

// File: tb/tb_strict_priority_multi_fifo.sv
// tb_strict_priority_multi_fifo: clock, reset and command stimulus for the priority fifo,
// directed corner words first, then random insert/remove traffic under varying idle rates
// depends on spmf_pkg, strict_priority_multi_fifo and spmf_checker
module tb_strict_priority_multi_fifo;
   timeunit 1ns;
   timeprecision 1ps;
   import spmf_pkg::*;

   localparam int RANDOM_WORDS = 1680;
   localparam int DRAIN_LIMIT  = 2000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_kind = 1'b0;
   logic [PRIO_W-1:0]         req_priority_req = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_strobe;
   logic [STATUS_W-1:0]       rsp_status;
   logic signed [VALUE_W-1:0] rsp_out_value;
   logic [PRIO_W-1:0]         rsp_served_level;
   int                        error_count;
   int                        pending_count;
   int                        idle_pct = 0;

   always #10 clock = ~clock;

   strict_priority_multi_fifo i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_priority_req (req_priority_req),
      .req_value        (req_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_out_value    (rsp_out_value),
      .rsp_served_level (rsp_served_level)
   );

   spmf_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_priority_req (req_priority_req),
      .req_value        (req_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_out_value    (rsp_out_value),
      .rsp_served_level (rsp_served_level),
      .error_count      (error_count),
      .pending_count    (pending_count)
   );

   // returns in the time step of the edge that accepts the word, start still high
   task automatic issue_word(input logic kind, input logic [PRIO_W-1:0] prio,
                             input logic signed [VALUE_W-1:0] value);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_kind         <= kind;
      req_priority_req <= prio;
      req_value        <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(7))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return '0;
         3:       return -1;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int                        insert_bias;
      int                        waited;
      logic [PRIO_W-1:0]         prio;
      insert_bias = 50;
      waited      = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      issue_word(KIND_REMOVE, 3'd7, 32'shffff_ffff);
      issue_word(KIND_INSERT, 3'd0, 32'sh1234_5678);
      issue_word(KIND_INSERT, 3'd7, 32'sh7fff_ffff);
      issue_word(KIND_INSERT, 3'd5, 32'sh8000_0000);
      issue_word(KIND_INSERT, 3'd6, -1);
      issue_word(KIND_INSERT, PRIO_W'(LEVELS), 32'sh8000_0000);
      issue_word(KIND_INSERT, PRIO_W'(LEVELS), 32'sh7fff_ffff);
      issue_word(KIND_INSERT, PRIO_W'(LEVELS), '0);
      issue_word(KIND_INSERT, PRIO_W'(LEVELS), -1);
      issue_word(KIND_INSERT, PRIO_W'(LEVELS), 32'sh0bad_0bad);
      issue_word(KIND_INSERT, 3'd1, 32'sh5555_5555);
      issue_word(KIND_INSERT, 3'd2, 32'shaaaa_aaaa);
      issue_word(KIND_INSERT, 3'd3, 32'sh0000_0001);
      issue_word(KIND_REMOVE, 3'd0, '0);
      issue_word(KIND_REMOVE, 3'd7, -1);
      issue_word(KIND_REMOVE, 3'd2, 32'sh5555_5555);
      repeat (4) issue_word(KIND_REMOVE, 3'd1, $urandom);
      issue_word(KIND_REMOVE, 3'd4, 32'shaaaa_aaaa);

      // random traffic, insert bias drifts so levels fill up and drain
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n < RANDOM_WORDS / 3) idle_pct = 35;
         else if (n < 2 * RANDOM_WORDS / 3) idle_pct = 78;
         else idle_pct = 0;
         if (n % 64 == 0) insert_bias = $urandom_range(25, 80);
         if ($urandom_range(99) < 8) begin
            prio = PRIO_W'($urandom_range(3));
            if (prio != 0) prio = prio + PRIO_W'(LEVELS);
            issue_word(KIND_INSERT, prio, pick_value());
         end else if ($urandom_range(99) < insert_bias) begin
            issue_word(KIND_INSERT, PRIO_W'($urandom_range(1, LEVELS)), pick_value());
         end else begin
            issue_word(KIND_REMOVE, PRIO_W'($urandom_range(7)), pick_value());
         end
      end
      start <= 1'b0;

      @(posedge clock);
      while (pending_count != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_count != 0) begin
         $display("DONE: errors detected");
      end else begin
         repeat (8) @(posedge clock);
         if (error_count == 0) begin
            $display("DONE: 0 errors");
         end else begin
            $display("DONE: errors detected");
         end
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
